### rtl/core/beacon_neighbor_table_aging_core_defines.svh
// Assertion macros for the RTL of the beacon neighbor table.
// Each assertion samples on clk_i and is disabled while rst_ni is low.
`ifndef BEACON_NEIGHBOR_TABLE_AGING_CORE_DEFINES_SVH
`define BEACON_NEIGHBOR_TABLE_AGING_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge out of reset.
`define BNTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never occurs out of reset.
`define BNTA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define BNTA_ASSERT(lbl, prop, msg)
`define BNTA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/core/bnta_pkg.sv
package bnta_pkg;

  // Table geometry
  localparam int MAX_DEVICES = 16;
  localparam int IDX_W       = $clog2(MAX_DEVICES);
  localparam int CNT_W       = $clog2(MAX_DEVICES + 1);

  // Beacon frame format
  localparam logic [31:0] HDR_MAGIC   = 32'h5052_5842;
  localparam logic [7:0]  BEACON_LEN  = 8'd27;
  localparam logic [7:0]  BEACON_VER  = 8'd1;
  localparam logic [31:0] STALE_RESET = 32'd30000;

  // Item opcodes
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_PRUNE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result status codes
  localparam logic [3:0] STAT_OWN     = 4'd0;
  localparam logic [3:0] STAT_EMPTY   = 4'd1;
  localparam logic [3:0] STAT_OTHER   = 4'd2;
  localparam logic [3:0] STAT_BAD     = 4'd3;
  localparam logic [3:0] STAT_FULL    = 4'd4;
  localparam logic [3:0] STAT_ADDED   = 4'd5;
  localparam logic [3:0] STAT_UPDATED = 4'd6;
  localparam logic [3:0] STAT_PRUNED  = 4'd7;
  localparam logic [3:0] STAT_READ_OK = 4'd8;
  localparam logic [3:0] STAT_BAD_IDX = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_MAC     = 2'd0;
  localparam logic [1:0] CFG_STALE_TIME  = 2'd1;
  localparam logic [1:0] CFG_BEACON_TYPE = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        now_ms;
    logic [47:0]        src_mac;
    logic signed [7:0]  rssi;
    logic [7:0]         frame_len;
    logic [7:0]         frame_type;
    logic [31:0]        magic_word;
    logic [7:0]         proto_version;
    logic [7:0]         capability_bits;
    logic [7:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [4:0]         device_count;
    logic [47:0]        entry_mac;
    logic [7:0]         entry_caps;
    logic signed [7:0]  entry_rssi;
    logic [31:0]        entry_first_seen;
    logic [31:0]        entry_last_seen;
    logic [4:0]         removed_count;
  } out_item_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] stale_time_ms;
    logic [7:0]  beacon_type_code;
  } cfg_t;

  typedef struct packed {
    logic [47:0]        mac;
    logic [7:0]         caps;
    logic signed [7:0]  rssi;
    logic [31:0]        first_seen;
    logic [31:0]        last_seen;
  } entry_t;

  // Control from the top level to the table engine
  typedef struct packed {
    logic start;
    logic res_free;
  } eng_ctl_t;

  // Status from the table engine to the top level
  typedef struct packed {
    logic idle;
    logic done;
  } eng_sts_t;

endpackage

### rtl/core/bnta_engine.sv
module bnta_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bnta_pkg::eng_ctl_t   ctl_i,
  input  bnta_pkg::cfg_t       cfg_i,
  input  bnta_pkg::in_item_t   item_i,
  output bnta_pkg::eng_sts_t   sts_o,
  output bnta_pkg::out_item_t  res_o
);
  import bnta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PRUNE,
    S_READ,
    S_FINISH
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  total_q;
  logic [CNT_W-1:0]  k_q;
  logic [CNT_W-1:0]  wr_q;
  logic [CNT_W-1:0]  rem_q;
  in_item_t          item_q;
  out_item_t         res_q;
  out_item_t         res_init;

  // Table storage, one port written and one port read per cycle
  entry_t            mem_q [MAX_DEVICES];
  entry_t            rd_data_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic [CNT_W-1:0]  k_next;
  logic              in_range;
  logic              mac_hit;
  logic [31:0]       age;
  logic              stale;
  logic              chk_drop;
  logic [3:0]        chk_status;
  logic              idx_ok;

  // Shared walk datapath: one MAC compare and one age subtract
  assign k_next   = k_q + CNT_W'(1);
  assign in_range = (k_q < total_q);
  assign mac_hit  = (rd_data_q.mac == item_q.src_mac);
  assign age      = item_q.now_ms - rd_data_q.last_seen;
  assign stale    = (age >= cfg_i.stale_time_ms);
  assign idx_ok   = (item_i.read_index < 8'(total_q));

  // Classify an incoming frame before any table walk
  always_comb begin
    chk_drop   = 1'b1;
    chk_status = STAT_BAD;
    if (item_i.src_mac == cfg_i.own_mac) begin
      chk_status = STAT_OWN;
    end else if (item_i.frame_len == 8'd0) begin
      chk_status = STAT_EMPTY;
    end else if (item_i.frame_type != cfg_i.beacon_type_code) begin
      chk_status = STAT_OTHER;
    end else if ((item_i.frame_len != BEACON_LEN) ||
                 (item_i.magic_word != HDR_MAGIC) ||
                 (item_i.proto_version != BEACON_VER)) begin
      chk_status = STAT_BAD;
    end else begin
      chk_drop = 1'b0;
    end
  end

  // Seed the result at dispatch; items that finish at once keep this status
  always_comb begin
    res_init              = '0;
    res_init.device_count = 5'(total_q);
    case (item_i.opcode)
      OP_FRAME: res_init.status = chk_status;
      OP_PRUNE: res_init.status = STAT_PRUNED;
      default:  res_init.status = STAT_BAD_IDX;
    endcase
  end

  // Drive table read address and write strobes
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = k_q[IDX_W-1:0];
    wr_data = rd_data_q;
    case (state_q)
      S_IDLE: begin
        if (item_i.opcode == OP_READ) begin
          rd_addr = item_i.read_index[IDX_W-1:0];
        end
      end
      S_SEARCH: begin
        rd_addr = k_next[IDX_W-1:0];
        if (in_range) begin
          if (mac_hit) begin
            wr_en              = 1'b1;
            wr_data.caps       = item_q.capability_bits;
            wr_data.rssi       = item_q.rssi;
            wr_data.last_seen  = item_q.now_ms;
          end
        end else if (total_q < CNT_W'(MAX_DEVICES)) begin
          wr_en              = 1'b1;
          wr_addr            = total_q[IDX_W-1:0];
          wr_data.mac        = item_q.src_mac;
          wr_data.caps       = item_q.capability_bits;
          wr_data.rssi       = item_q.rssi;
          wr_data.first_seen = item_q.now_ms;
          wr_data.last_seen  = item_q.now_ms;
        end
      end
      S_PRUNE: begin
        rd_addr = k_next[IDX_W-1:0];
        if (in_range && !stale && (wr_q != k_q)) begin
          wr_en   = 1'b1;
          wr_addr = wr_q[IDX_W-1:0];
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer: dispatch, walk the table, build the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      k_q     <= '0;
      wr_q    <= '0;
      rem_q   <= '0;
      item_q  <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (ctl_i.start) begin
            item_q <= item_i;
            k_q    <= '0;
            wr_q   <= '0;
            rem_q  <= '0;
            res_q  <= res_init;
            case (item_i.opcode)
              OP_FRAME: begin
                if (chk_drop) begin
                  state_q <= S_FINISH;
                end else begin
                  state_q <= S_SEARCH;
                end
              end
              OP_PRUNE: begin
                state_q <= S_PRUNE;
              end
              OP_READ: begin
                if (idx_ok) begin
                  state_q <= S_READ;
                end else begin
                  state_q <= S_FINISH;
                end
              end
              default: begin
                state_q <= S_FINISH;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (in_range) begin
            if (mac_hit) begin
              res_q.status <= STAT_UPDATED;
              state_q      <= S_FINISH;
            end else begin
              k_q <= k_next;
            end
          end else if (total_q >= CNT_W'(MAX_DEVICES)) begin
            res_q.status <= STAT_FULL;
            state_q      <= S_FINISH;
          end else begin
            total_q            <= total_q + CNT_W'(1);
            res_q.device_count <= 5'(total_q + CNT_W'(1));
            res_q.status       <= STAT_ADDED;
            state_q            <= S_FINISH;
          end
        end
        S_PRUNE: begin
          if (in_range) begin
            k_q <= k_next;
            if (stale) begin
              rem_q <= rem_q + CNT_W'(1);
            end else begin
              wr_q <= wr_q + CNT_W'(1);
            end
          end else begin
            total_q             <= wr_q;
            res_q.status        <= STAT_PRUNED;
            res_q.device_count  <= 5'(wr_q);
            res_q.removed_count <= 5'(rem_q);
            state_q             <= S_FINISH;
          end
        end
        S_READ: begin
          res_q.status           <= STAT_READ_OK;
          res_q.entry_mac        <= rd_data_q.mac;
          res_q.entry_caps       <= rd_data_q.caps;
          res_q.entry_rssi       <= rd_data_q.rssi;
          res_q.entry_first_seen <= rd_data_q.first_seen;
          res_q.entry_last_seen  <= rd_data_q.last_seen;
          state_q                <= S_FINISH;
        end
        S_FINISH: begin
          // hold the result until the output register has room
          if (ctl_i.res_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign sts_o.idle = (state_q == S_IDLE);
  assign sts_o.done = (state_q == S_FINISH) && ctl_i.res_free;
  assign res_o      = res_q;

endmodule

### rtl/core/beacon_neighbor_table_aging_core.sv
// Beacon neighbor table with aging. Keeps a packed table of up to 16 devices
// learned from beacon frames; each input item (frame, prune tick, or read by
// index) gives exactly one result transfer. Items are handled one at a time
// by a sequencer that walks the table through an entry memory with one read
// and one write port at one entry per cycle, so in_ready_o is low while an
// item is in work. A frame rejected by its header checks goes straight to the
// finish state; a valid beacon walks the entries in a MAC search; a prune tick
// walks all entries to compact the table; a read of a valid index fetches that
// entry. A finished result sits in the output register, and the next item is
// taken while it waits. Configuration writes are to be made only while the
// block is idle; the block itself does not enforce this.
module beacon_neighbor_table_aging_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bnta_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bnta_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [47:0]          cfg_wdata_i
);
  import bnta_pkg::*;

  `include "beacon_neighbor_table_aging_core_defines.svh"

  cfg_t       cfg_q;
  eng_ctl_t   eng_ctl;
  eng_sts_t   eng_sts;
  out_item_t  eng_res;
  logic       out_valid_q;
  out_item_t  out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_mac          <= '0;
      cfg_q.stale_time_ms    <= STALE_RESET;
      cfg_q.beacon_type_code <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OWN_MAC:     cfg_q.own_mac          <= cfg_wdata_i;
        CFG_STALE_TIME:  cfg_q.stale_time_ms    <= cfg_wdata_i[31:0];
        CFG_BEACON_TYPE: cfg_q.beacon_type_code <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Start an item on an input transfer; let the engine finish when the slot frees
  assign in_ready_o       = eng_sts.idle;
  assign eng_ctl.start    = in_valid_i && in_ready_o;
  assign eng_ctl.res_free = !out_valid_q || out_ready_i;

  bnta_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (eng_ctl),
    .cfg_i  (cfg_q),
    .item_i (in_item_i),
    .sts_o  (eng_sts),
    .res_o  (eng_res)
  );

  // Output register: load a finished result, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (eng_sts.done) begin
      out_valid_q <= 1'b1;
      out_q       <= eng_res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `BNTA_ASSERT(a_busy_after_start, eng_ctl.start |=> !in_ready_o,
    "ready after input transfer")
  `BNTA_ASSERT_NEVER(a_no_overwrite, eng_sts.done && out_valid_q && !out_ready_i,
    "result overwritten")
  `BNTA_ASSERT(a_count_bound,
    out_valid_o |-> (out_item_o.device_count <= 5'(MAX_DEVICES)),
    "device count too large")
  `BNTA_ASSERT(a_removed_prune_only,
    (out_valid_o && (out_item_o.status != STAT_PRUNED)) |-> (out_item_o.removed_count == 5'd0),
    "removed count outside prune")

endmodule

### verif/tb_top.sv
module tb_top;
  import bnta_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned MAC_POOL = 22;
  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  typedef struct {
    cfg_t        cfg;
    int unsigned step;
    bit          calm;
  } phase_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_OWN_MAC;
  logic [47:0] cfg_wdata_i = '0;

  // Predicted neighbor table and register copy
  cfg_t        node_cfg;
  entry_t      nbr_tab [MAX_DEVICES];
  int unsigned nbr_count;

  out_item_t   expected_results [$];
  out_item_t   got_want;
  int unsigned failures = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  logic [31:0] clock_ms = '0;
  int unsigned step_max = 100;
  logic [47:0] mac_pool [MAC_POOL];

  beacon_neighbor_table_aging_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Work out the result of one item and advance the predicted table
  function automatic out_item_t neighbor_table_result(in_item_t it);
    out_item_t   r;
    int          pos;
    int unsigned wr;
    logic [31:0] age;
    r = '0;
    case (it.opcode)
      OP_FRAME: begin
        if (it.src_mac == node_cfg.own_mac) r.status = STAT_OWN;
        else if (it.frame_len == 8'd0) r.status = STAT_EMPTY;
        else if (it.frame_type != node_cfg.beacon_type_code) r.status = STAT_OTHER;
        else if (it.frame_len != BEACON_LEN || it.magic_word != HDR_MAGIC ||
                 it.proto_version != BEACON_VER) r.status = STAT_BAD;
        else begin
          pos = -1;
          for (int k = 0; k < nbr_count; k++)
            if (pos < 0 && nbr_tab[k].mac == it.src_mac) pos = k;
          if (pos < 0 && nbr_count >= MAX_DEVICES) begin
            r.status = STAT_FULL;
          end else begin
            if (pos < 0) begin
              pos = nbr_count;
              nbr_count++;
              nbr_tab[pos].mac = it.src_mac;
              nbr_tab[pos].first_seen = it.now_ms;
              r.status = STAT_ADDED;
            end else begin
              r.status = STAT_UPDATED;
            end
            nbr_tab[pos].caps = it.capability_bits;
            nbr_tab[pos].rssi = it.rssi;
            nbr_tab[pos].last_seen = it.now_ms;
          end
        end
      end
      OP_PRUNE: begin
        // Drop stale entries, compact the rest in order
        wr = 0;
        for (int rd = 0; rd < nbr_count; rd++) begin
          age = it.now_ms - nbr_tab[rd].last_seen;
          if (age >= node_cfg.stale_time_ms) r.removed_count++;
          else begin
            nbr_tab[wr] = nbr_tab[rd];
            wr++;
          end
        end
        nbr_count = wr;
        r.status = STAT_PRUNED;
      end
      OP_READ: begin
        if (it.read_index < nbr_count) begin
          r.status = STAT_READ_OK;
          r.entry_mac = nbr_tab[it.read_index].mac;
          r.entry_caps = nbr_tab[it.read_index].caps;
          r.entry_rssi = nbr_tab[it.read_index].rssi;
          r.entry_first_seen = nbr_tab[it.read_index].first_seen;
          r.entry_last_seen = nbr_tab[it.read_index].last_seen;
        end else begin
          r.status = STAT_BAD_IDX;
        end
      end
      default: r.status = STAT_BAD_IDX;
    endcase
    r.device_count = 5'(nbr_count);
    return r;
  endfunction

  function automatic in_item_t beacon(logic [47:0] mac, logic [31:0] now,
                                      logic signed [7:0] rssi, logic [7:0] caps);
    return in_item_t'{OP_FRAME, now, mac, rssi, BEACON_LEN, node_cfg.beacon_type_code,
                      HDR_MAGIC, BEACON_VER, caps, 8'd0};
  endfunction

  function automatic in_item_t request(logic [1:0] op, logic [31:0] now, logic [7:0] idx);
    return in_item_t'{op, now, 48'd7, 8'sd0, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0, idx};
  endfunction

  function automatic out_item_t outcome(logic [3:0] status, logic [4:0] count);
    out_item_t r;
    r = '0;
    r.status = status;
    r.device_count = count;
    return r;
  endfunction

  // Draw one random item: beacons (some of them broken), prune ticks, reads and unused opcodes
  function automatic in_item_t draw_item();
    in_item_t    it;
    int unsigned pick;
    if ($urandom_range(99) < 2) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, step_max);
    it.now_ms = clock_ms;
    it.src_mac = mac_pool[$urandom_range(MAC_POOL - 1)];
    it.rssi = 8'($urandom);
    it.frame_len = BEACON_LEN;
    it.frame_type = node_cfg.beacon_type_code;
    it.magic_word = HDR_MAGIC;
    it.proto_version = BEACON_VER;
    it.capability_bits = 8'($urandom);
    it.read_index = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.opcode = OP_FRAME;
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(6))
          0: it.src_mac = node_cfg.own_mac;
          1: it.frame_len = 8'd0;
          2: it.frame_type = node_cfg.beacon_type_code ^ 8'($urandom_range(1, 255));
          3: it.frame_len = 8'($urandom);
          4: it.magic_word = $urandom;
          5: it.proto_version = 8'($urandom);
          default: begin
            it.src_mac = 48'({$urandom, $urandom});
            it.frame_len = 8'($urandom);
            it.frame_type = 8'($urandom);
            it.magic_word = $urandom;
            it.proto_version = 8'($urandom);
          end
        endcase
      end
    end else if (pick < 70) begin
      it.opcode = OP_PRUNE;
    end else if (pick < 95) begin
      it.opcode = OP_READ;
      if ($urandom_range(3) != 0) it.read_index = 8'($urandom_range(0, nbr_count));
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then predict its result
  task automatic transfer_in(input in_item_t it, output out_item_t pred);
    if (!quiet && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pred = neighbor_table_result(it);
  endtask

  // Wait for all pending results, then let the engine go idle
  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic apply_config(cfg_t c);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_OWN_MAC;
    cfg_wdata_i <= c.own_mac;
    @(posedge clk_i);
    cfg_index_i <= CFG_STALE_TIME;
    cfg_wdata_i <= {16'd0, c.stale_time_ms};
    @(posedge clk_i);
    cfg_index_i <= CFG_BEACON_TYPE;
    cfg_wdata_i <= {40'd0, c.beacon_type_code};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    node_cfg = c;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Receiver: stall at random except during calm stretches
  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 16);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no item pending: status %0d", out_item_o.status);
        failures++;
      end else begin
        got_want = expected_results.pop_front();
        check_field("status", got_want.status, out_item_o.status);
        check_field("device_count", got_want.device_count, out_item_o.device_count);
        check_field("entry_mac", got_want.entry_mac, out_item_o.entry_mac);
        check_field("entry_caps", got_want.entry_caps, out_item_o.entry_caps);
        check_field("entry_rssi", $unsigned(got_want.entry_rssi),
                    $unsigned(out_item_o.entry_rssi));
        check_field("entry_first_seen", got_want.entry_first_seen,
                    out_item_o.entry_first_seen);
        check_field("entry_last_seen", got_want.entry_last_seen,
                    out_item_o.entry_last_seen);
        check_field("removed_count", got_want.removed_count, out_item_o.removed_count);
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stim
    dir_row_t  dir_rows [$];
    phase_t    phases [$];
    out_item_t pred;
    in_item_t  it;

    node_cfg = cfg_t'{48'd0, STALE_RESET, 8'd0};
    nbr_count = 0;
    foreach (nbr_tab[k]) nbr_tab[k] = '0;

    // Directed rows under the reset register values
    dir_rows.push_back('{request(OP_READ, 32'd0, 8'd0), 1'b1, outcome(STAT_BAD_IDX, 5'd0)});
    dir_rows.push_back('{request(OP_PRUNE, 32'd0, 8'd0), 1'b1, outcome(STAT_PRUNED, 5'd0)});
    dir_rows.push_back('{beacon(48'd0, 32'd1, 8'sd0, 8'd0), 1'b1, outcome(STAT_OWN, 5'd0)});
    dir_rows.push_back('{request(OP_UNUSED, 32'd1, 8'd0), 1'b1,
                         outcome(STAT_BAD_IDX, 5'd0)});
    dir_rows.push_back('{in_item_t'{OP_FRAME, 32'd2, 48'd1, 8'sd0, 8'd0, 8'd0, HDR_MAGIC,
                                    BEACON_VER, 8'd0, 8'd0}, 1'b1, outcome(STAT_EMPTY, 5'd0)});
    dir_rows.push_back('{in_item_t'{OP_FRAME, 32'd2, 48'd1, 8'sd0, BEACON_LEN, 8'd1,
                                    HDR_MAGIC, BEACON_VER, 8'd0, 8'd0}, 1'b1,
                         outcome(STAT_OTHER, 5'd0)});
    dir_rows.push_back('{in_item_t'{OP_FRAME, 32'd2, 48'd1, 8'sd0, 8'd26, 8'd0,
                                    HDR_MAGIC, BEACON_VER, 8'd0, 8'd0}, 1'b1,
                         outcome(STAT_BAD, 5'd0)});
    dir_rows.push_back('{in_item_t'{OP_FRAME, 32'd2, 48'd1, 8'sd0, 8'd255, 8'd0,
                                    HDR_MAGIC, BEACON_VER, 8'd0, 8'd0}, 1'b1,
                         outcome(STAT_BAD, 5'd0)});
    dir_rows.push_back('{in_item_t'{OP_FRAME, 32'd2, 48'd1, 8'sd0, BEACON_LEN, 8'd0,
                                    32'd0, BEACON_VER, 8'd0, 8'd0}, 1'b1,
                         outcome(STAT_BAD, 5'd0)});
    dir_rows.push_back('{in_item_t'{OP_FRAME, 32'd2, 48'd1, 8'sd0, BEACON_LEN, 8'd0,
                                    HDR_MAGIC, 8'd0, 8'd0, 8'd0}, 1'b1,
                         outcome(STAT_BAD, 5'd0)});
    dir_rows.push_back('{beacon(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, -8'sd128, 8'hFF), 1'b1,
                         outcome(STAT_ADDED, 5'd1)});
    dir_rows.push_back('{request(OP_READ, 32'd3, 8'd0), 1'b1,
                         out_item_t'{STAT_READ_OK, 5'd1, 48'hFFFF_FFFF_FFFF, 8'hFF, -8'sd128,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0}});
    dir_rows.push_back('{beacon(48'hFFFF_FFFF_FFFF, 32'd5, 8'sd127, 8'h00), 1'b1,
                         outcome(STAT_UPDATED, 5'd1)});
    dir_rows.push_back('{request(OP_READ, 32'd6, 8'd0), 1'b0, '0});
    dir_rows.push_back('{beacon(48'd1, 32'd10, -8'sd40, 8'h5A), 1'b1,
                         outcome(STAT_ADDED, 5'd2)});
    dir_rows.push_back('{request(OP_READ, 32'd11, 8'd255), 1'b1,
                         outcome(STAT_BAD_IDX, 5'd2)});
    dir_rows.push_back('{beacon(48'd2, 32'd30004, -8'sd70, 8'hA5), 1'b1,
                         outcome(STAT_ADDED, 5'd3)});
    // First entry reaches the stale age exactly; the others shift down
    dir_rows.push_back('{request(OP_PRUNE, 32'd30005, 8'd0), 1'b0, '0});
    dir_rows.push_back('{request(OP_READ, 32'd30006, 8'd0), 1'b0, '0});
    dir_rows.push_back('{request(OP_READ, 32'd30006, 8'd1), 1'b0, '0});

    // Register settings for the random part, extremes among them
    phases.push_back('{cfg_t'{48'({$urandom, $urandom}), 32'd30000, 8'($urandom)}, 400, 1'b0});
    phases.push_back('{cfg_t'{48'd0, 32'd0, 8'd0}, 50, 1'b0});
    phases.push_back('{cfg_t'{48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 5000, 1'b1});
    phases.push_back('{cfg_t'{48'({$urandom, $urandom}), 32'd2500, 8'($urandom)}, 300, 1'b0});
    phases.push_back('{cfg_t'{48'({$urandom, $urandom}), 32'd1, 8'h80}, 2, 1'b0});
    phases.push_back('{cfg_t'{48'({$urandom, $urandom}), 32'd30000, 8'($urandom)}, 2000,
                       1'b0});

    // Hold reset, then start at a clock edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      transfer_in(dir_rows[i].item, pred);
      expected_results.push_back(dir_rows[i].typed ? dir_rows[i].want : pred);
    end
    in_valid_i <= 1'b0;

    foreach (phases[p]) begin
      drain();
      apply_config(phases[p].cfg);
      quiet = phases[p].calm;
      step_max = phases[p].step;
      for (int m = 0; m < MAC_POOL - 2; m++) mac_pool[m] = 48'({$urandom, $urandom});
      mac_pool[MAC_POOL - 2] = '0;
      mac_pool[MAC_POOL - 1] = '1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = draw_item();
        transfer_in(it, pred);
        expected_results.push_back(pred);
      end
      in_valid_i <= 1'b0;
    end

    drain();
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bnta_pkg.sv
rtl/core/bnta_engine.sv
rtl/core/beacon_neighbor_table_aging_core.sv
verif/tb_top.sv
